// ----- hw/rtl/ldf_pkg.sv -----
// shared types, constants and codes for the link frame deframer
package ldf_pkg;

  localparam int unsigned PAYLOAD_LIMIT = 65535;
  localparam int unsigned HDR_STORE_DEPTH = 15;
  localparam logic [3:0] HDR_LAST_INDEX = 4'd15;

  localparam logic [15:0] PAYLOAD_LIMIT_W = 16'(PAYLOAD_LIMIT);

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_MAGIC = 2'd1;
  localparam logic [1:0] ERR_VERSION = 2'd2;
  localparam logic [1:0] ERR_LENGTH = 2'd3;

  localparam logic [1:0] REG_MAGIC = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

  localparam logic [31:0] MAGIC_RESET = 32'd0;
  localparam logic [15:0] VERSION_RESET = 16'd1;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hFFFF;

  typedef struct packed {
    logic [31:0] expected_magic;
    logic [15:0] expected_version;
    logic [15:0] max_payload;
  } ldf_cfg_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] frame_type;
    logic [31:0] frame_sequence;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic [1:0]  error_code;
  } ldf_result_t;

endpackage

// ----- hw/rtl/ldf_regs.sv -----
// apb configuration registers of the deframer
module ldf_regs
  import ldf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output ldf_cfg_t    cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_magic <= MAGIC_RESET;
      cfg.expected_version <= VERSION_RESET;
      cfg.max_payload <= MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_MAGIC: cfg.expected_magic <= pwdata;
        REG_VERSION: cfg.expected_version <= pwdata[15:0];
        REG_MAX_PAYLOAD: cfg.max_payload <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_MAGIC: prdata = cfg.expected_magic;
      REG_VERSION: prdata = {16'd0, cfg.expected_version};
      REG_MAX_PAYLOAD: prdata = {16'd0, cfg.max_payload};
      default: prdata = 32'd0;
    endcase
  end

endmodule

// ----- hw/rtl/ldf_parser.sv -----
// header collection, header checks and payload counting
module ldf_parser
  import ldf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  ldf_cfg_t    cfg,
  output logic        push,
  output ldf_result_t result
);

  logic [7:0]  header_store [HDR_STORE_DEPTH];
  logic [3:0]  header_count;
  logic        in_payload;
  logic [15:0] bytes_left;

  logic [3:0]  header_count_next;
  logic        in_payload_next;
  logic [15:0] bytes_left_next;
  logic        store_en;

  logic [31:0] hdr_magic;
  logic [15:0] hdr_version;
  logic [31:0] hdr_length;
  logic [15:0] limit;
  logic [15:0] bytes_dec;

  assign hdr_magic = {header_store[3], header_store[2], header_store[1], header_store[0]};
  assign hdr_version = {header_store[5], header_store[4]};
  assign hdr_length = {rx_byte, header_store[14], header_store[13], header_store[12]};
  assign limit = (cfg.max_payload < PAYLOAD_LIMIT_W) ? cfg.max_payload : PAYLOAD_LIMIT_W;
  assign bytes_dec = bytes_left - 16'd1;

  always_comb begin
    header_count_next = header_count;
    in_payload_next = in_payload;
    bytes_left_next = bytes_left;
    store_en = 1'b0;
    push = 1'b0;
    result = '0;
    if (accept) begin
      if (in_payload) begin
        push = 1'b1;
        bytes_left_next = bytes_dec;
        result.result_kind = KIND_PAYLOAD;
        result.payload_byte = rx_byte;
        if (bytes_dec == 16'd0) begin
          result.last_of_frame = 1'b1;
          in_payload_next = 1'b0;
        end
      end else if (header_count != HDR_LAST_INDEX) begin
        store_en = 1'b1;
        header_count_next = header_count + 4'd1;
      end else begin
        push = 1'b1;
        header_count_next = 4'd0;
        if (hdr_magic != cfg.expected_magic) begin
          result.result_kind = KIND_ERROR;
          result.error_code = ERR_MAGIC;
        end else if (hdr_version != cfg.expected_version) begin
          result.result_kind = KIND_ERROR;
          result.error_code = ERR_VERSION;
        end else if (hdr_length > {16'd0, limit}) begin
          result.result_kind = KIND_ERROR;
          result.error_code = ERR_LENGTH;
        end else begin
          result.result_kind = KIND_HEADER;
          result.frame_type = {header_store[7], header_store[6]};
          result.frame_sequence = {header_store[11], header_store[10],
                                   header_store[9], header_store[8]};
          result.payload_length = hdr_length[15:0];
          if (hdr_length == 32'd0) begin
            result.last_of_frame = 1'b1;
          end else begin
            in_payload_next = 1'b1;
            bytes_left_next = hdr_length[15:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= 4'd0;
      in_payload <= 1'b0;
      bytes_left <= 16'd0;
    end else begin
      header_count <= header_count_next;
      in_payload <= in_payload_next;
      bytes_left <= bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      header_store[header_count] <= rx_byte;
    end
  end

endmodule

// ----- hw/rtl/ldf_out_queue.sv -----
// two-entry result register queue toward the receiver
module ldf_out_queue
  import ldf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  ldf_result_t push_data,
  output logic        full,
  output logic        valid,
  input  logic        stall,
  output ldf_result_t data
);

  ldf_result_t entry [2];
  logic [1:0]  count;
  logic        pop;

  assign pop = valid && !stall;
  assign valid = (count != 2'd0);
  assign full = (count == 2'd2);
  assign data = entry[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      entry[0] <= (count == 2'd2) ? entry[1] : push_data;
      if (push) begin
        entry[1] <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        entry[0] <= push_data;
      end else begin
        entry[1] <= push_data;
      end
    end
  end

endmodule

// ----- hw/rtl/link_frame_deframer.sv -----
// top level of the link frame deframer
//
// rx channel: one byte per transaction on rx_byte, taken when rx_valid is
// high and rx_stall is low. the first 15 header bytes give no result; the
// 16th gives a header or error result, and each payload byte gives one
// payload result, last_of_frame marking the end of a frame.
// res channel: one result per transaction, held while res_stall is high.
// results: each result enters the output queue when the byte that causes
// it is taken, and shows on res_valid once the results ahead have left.
// throughput: one byte per cycle while rx_stall is low; the header check is
// combinational and results leave through a two-entry queue.
// receiver stall: the queue absorbs one more result, then rx_stall rises
// and stays high until the receiver takes a result from the queue.
// reset: rst, synchronous, returns to header collection with an empty
// queue and restores the register defaults. the user is to write registers
// via the apb port only while idle; the block itself does not enforce it.
module link_frame_deframer
  import ldf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  result_kind,
  output logic [15:0] frame_type,
  output logic [31:0] frame_sequence,
  output logic [15:0] payload_length,
  output logic [7:0]  payload_byte,
  output logic        last_of_frame,
  output logic [1:0]  error_code
);

  ldf_cfg_t    cfg;
  ldf_result_t parsed;
  ldf_result_t queued;
  logic        push;
  logic        full;
  logic        accept;

  assign rx_stall = full;
  assign accept = rx_valid && !rx_stall;

  ldf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ldf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .push    (push),
    .result  (parsed)
  );

  ldf_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (parsed),
    .full      (full),
    .valid     (res_valid),
    .stall     (res_stall),
    .data      (queued)
  );

  assign result_kind = queued.result_kind;
  assign frame_type = queued.frame_type;
  assign frame_sequence = queued.frame_sequence;
  assign payload_length = queued.payload_length;
  assign payload_byte = queued.payload_byte;
  assign last_of_frame = queued.last_of_frame;
  assign error_code = queued.error_code;

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> res_valid)
    else $error("rx stalled with no result waiting");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (res_valid && result_kind == KIND_ERROR) |-> (!last_of_frame && error_code != ERR_NONE))
    else $error("error result malformed");

  a_good_no_code: assert property (@(posedge clk) disable iff (rst)
    (res_valid && result_kind != KIND_ERROR) |-> (error_code == ERR_NONE))
    else $error("error code on a good result");

  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (result_kind == KIND_HEADER || result_kind == KIND_PAYLOAD ||
                   result_kind == KIND_ERROR))
    else $error("unknown result kind");

endmodule

// ----- tb/ldf_frame_checker.sv -----
// frame deframer checker: watches both channels and the register port, predicts and compares
module ldf_frame_checker
  import ldf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        rx_valid,
  input  logic        rx_stall,
  input  logic [7:0]  rx_byte,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic [1:0]  result_kind,
  input  logic [15:0] frame_type,
  input  logic [31:0] frame_sequence,
  input  logic [15:0] payload_length,
  input  logic [7:0]  payload_byte,
  input  logic        last_of_frame,
  input  logic [1:0]  error_code,
  output int          mismatch_count,
  output int          outstanding
);

  logic [31:0] exp_magic;
  logic [15:0] exp_version;
  logic [15:0] max_payload;

  logic [7:0]  hdr_bytes [HDR_STORE_DEPTH];
  logic [3:0]  hdr_count;
  logic        in_payload;
  logic [15:0] bytes_left;

  ldf_result_t pending_results[$];
  int          fail_total = 0;

  initial begin
    mismatch_count = 0;
    outstanding = 0;
  end

  task automatic deframe_byte(input logic [7:0] b);
    ldf_result_t r;
    logic [31:0] magic_w;
    logic [31:0] seq_w;
    logic [31:0] len_w;
    logic [15:0] ver_w;
    logic [15:0] type_w;
    logic [15:0] limit;
    r = '0;
    if (in_payload) begin
      bytes_left = bytes_left - 16'd1;
      r.result_kind = KIND_PAYLOAD;
      r.payload_byte = b;
      if (bytes_left == 16'd0) begin
        r.last_of_frame = 1'b1;
        in_payload = 1'b0;
      end
      pending_results.push_back(r);
    end else if (hdr_count != HDR_LAST_INDEX) begin
      hdr_bytes[hdr_count] = b;
      hdr_count = hdr_count + 4'd1;
    end else begin
      hdr_count = 4'd0;
      magic_w = {hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]};
      ver_w = {hdr_bytes[5], hdr_bytes[4]};
      type_w = {hdr_bytes[7], hdr_bytes[6]};
      seq_w = {hdr_bytes[11], hdr_bytes[10], hdr_bytes[9], hdr_bytes[8]};
      len_w = {b, hdr_bytes[14], hdr_bytes[13], hdr_bytes[12]};
      limit = (max_payload < PAYLOAD_LIMIT_W) ? max_payload : PAYLOAD_LIMIT_W;
      if (magic_w != exp_magic) begin
        r.result_kind = KIND_ERROR;
        r.error_code = ERR_MAGIC;
      end else if (ver_w != exp_version) begin
        r.result_kind = KIND_ERROR;
        r.error_code = ERR_VERSION;
      end else if (len_w > {16'd0, limit}) begin
        r.result_kind = KIND_ERROR;
        r.error_code = ERR_LENGTH;
      end else begin
        r.result_kind = KIND_HEADER;
        r.frame_type = type_w;
        r.frame_sequence = seq_w;
        r.payload_length = len_w[15:0];
        if (len_w == 32'd0) begin
          r.last_of_frame = 1'b1;
        end else begin
          in_payload = 1'b1;
          bytes_left = len_w[15:0];
        end
      end
      pending_results.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input ldf_result_t want,
                                 input ldf_result_t seen);
    fail_total++;
    if (fail_total <= 10) begin
      $display("%0t %s (expected/actual): kind %0d/%0d type %h/%h seq %h/%h",
               $time, what, want.result_kind, seen.result_kind, want.frame_type,
               seen.frame_type, want.frame_sequence, seen.frame_sequence);
      $display("  len %h/%h byte %h/%h last %0d/%0d err %0d/%0d",
               want.payload_length, seen.payload_length, want.payload_byte,
               seen.payload_byte, want.last_of_frame, seen.last_of_frame,
               want.error_code, seen.error_code);
    end
  endtask

  always @(posedge clk) begin
    ldf_result_t want;
    ldf_result_t seen;
    if (rst) begin
      exp_magic = MAGIC_RESET;
      exp_version = VERSION_RESET;
      max_payload = MAX_PAYLOAD_RESET;
      hdr_count = 4'd0;
      in_payload = 1'b0;
      bytes_left = 16'd0;
      pending_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MAGIC:       exp_magic = pwdata;
          REG_VERSION:     exp_version = pwdata[15:0];
          REG_MAX_PAYLOAD: max_payload = pwdata[15:0];
          default: ;
        endcase
      end
      if (rx_valid && !rx_stall) deframe_byte(rx_byte);
      if (res_valid && !res_stall) begin
        seen.result_kind = result_kind;
        seen.frame_type = frame_type;
        seen.frame_sequence = frame_sequence;
        seen.payload_length = payload_length;
        seen.payload_byte = payload_byte;
        seen.last_of_frame = last_of_frame;
        seen.error_code = error_code;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", '0, seen);
        end else begin
          want = pending_results.pop_front();
          if (seen.result_kind !== want.result_kind ||
              seen.frame_type !== want.frame_type ||
              seen.frame_sequence !== want.frame_sequence ||
              seen.payload_length !== want.payload_length ||
              seen.payload_byte !== want.payload_byte ||
              seen.last_of_frame !== want.last_of_frame ||
              seen.error_code !== want.error_code) begin
            report_mismatch("result mismatch", want, seen);
          end
        end
      end
    end
    outstanding <= pending_results.size();
    mismatch_count <= fail_total;
  end

endmodule

// ----- tb/link_frame_deframer_tb.sv -----
// testbench top for the link frame deframer: stimulus, receiver stalls and verdict
module link_frame_deframer_tb;
  import ldf_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_BYTES_PER_PHASE = 110;
  localparam int QUIET_LIMIT = 2000;

  typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_HALF, STALL_RUNS} stall_mode_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = 8'd0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [15:0] frame_type;
  logic [31:0] frame_sequence;
  logic [15:0] payload_length;
  logic [7:0]  payload_byte;
  logic        last_of_frame;
  logic [1:0]  error_code;

  int mismatch_count;
  int outstanding;

  logic [7:0]  link_stream[$];
  logic [31:0] cur_magic;
  logic [15:0] cur_version;
  int          cur_limit;

  stall_mode_t stall_mode = STALL_NONE;
  int          mode_cycles = 0;
  int          stall_tick = 0;
  int          quiet_cycles = 0;

  link_frame_deframer uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
    .res_valid(res_valid), .res_stall(res_stall),
    .result_kind(result_kind), .frame_type(frame_type),
    .frame_sequence(frame_sequence), .payload_length(payload_length),
    .payload_byte(payload_byte), .last_of_frame(last_of_frame),
    .error_code(error_code)
  );

  ldf_frame_checker frame_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
    .res_valid(res_valid), .res_stall(res_stall),
    .result_kind(result_kind), .frame_type(frame_type),
    .frame_sequence(frame_sequence), .payload_length(payload_length),
    .payload_byte(payload_byte), .last_of_frame(last_of_frame),
    .error_code(error_code),
    .mismatch_count(mismatch_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_mode <= STALL_NONE;
      mode_cycles <= 0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (mode_cycles == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_cycles <= $urandom_range(16, 400);
      end else begin
        mode_cycles <= mode_cycles - 1;
      end
      case (stall_mode)
        STALL_NONE:   res_stall <= 1'b0;
        STALL_SPARSE: res_stall <= ($urandom_range(0, 7) == 0);
        STALL_HALF:   res_stall <= ($urandom_range(0, 1) == 1);
        default:      res_stall <= ((stall_tick % 13) < 9);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(input logic [1:0] index, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(input logic [31:0] magic, input logic [15:0] version,
                           input logic [15:0] maxp);
    reg_write(REG_MAGIC, magic);
    reg_write(REG_VERSION, {16'($urandom), version});
    reg_write(REG_MAX_PAYLOAD, {16'($urandom), maxp});
    reg_write(REG_UNUSED, $urandom);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    cur_magic = magic;
    cur_version = version;
    cur_limit = (maxp < PAYLOAD_LIMIT) ? int'(maxp) : int'(PAYLOAD_LIMIT);
  endtask

  task automatic queue_frame(input logic [31:0] magic, input logic [15:0] version,
                             input logic [15:0] ftype, input logic [31:0] seq,
                             input logic [31:0] len, input int n_payload);
    for (int i = 0; i < 4; i++) link_stream.push_back(magic[8*i +: 8]);
    for (int i = 0; i < 2; i++) link_stream.push_back(version[8*i +: 8]);
    for (int i = 0; i < 2; i++) link_stream.push_back(ftype[8*i +: 8]);
    for (int i = 0; i < 4; i++) link_stream.push_back(seq[8*i +: 8]);
    for (int i = 0; i < 4; i++) link_stream.push_back(len[8*i +: 8]);
    repeat (n_payload) link_stream.push_back(8'($urandom));
  endtask

  task automatic queue_random_frame();
    int pick;
    int span;
    logic [31:0] len;
    logic [31:0] excess;
    pick = $urandom_range(0, 15);
    span = (cur_limit < 20) ? cur_limit : 20;
    len = $urandom_range(0, span);
    excess = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(0, 99))
                                         : 32'($urandom_range(0, 32'hFFFE_0000));
    case (pick)
      11: queue_frame(cur_magic ^ (32'd1 << $urandom_range(0, 31)), cur_version,
                      16'($urandom), $urandom, len, 0);
      12: queue_frame(cur_magic, cur_version ^ (16'd1 << $urandom_range(0, 15)),
                      16'($urandom), $urandom, len, 0);
      13: queue_frame(cur_magic, cur_version, 16'($urandom), $urandom,
                      32'(cur_limit) + 32'd1 + excess, 0);
      14: repeat (16) link_stream.push_back(8'($urandom));
      15: begin
        span = (cur_limit < 300) ? cur_limit : 300;
        len = $urandom_range(0, span);
        queue_frame(cur_magic, cur_version, 16'($urandom), $urandom, len, int'(len));
      end
      default: queue_frame(cur_magic, cur_version, 16'($urandom), $urandom, len, int'(len));
    endcase
  endtask

  task automatic queue_random(input int target);
    int start;
    start = link_stream.size();
    while (link_stream.size() - start < target) queue_random_frame();
  endtask

  task automatic play_stream();
    int burst_left;
    int gap;
    burst_left = 0;
    while (link_stream.size() != 0) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          rx_valid <= 1'b0;
          rx_byte <= 8'($urandom);
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
      end
      rx_valid <= 1'b1;
      rx_byte <= link_stream.pop_front();
      @(posedge clk);
      while (rx_stall) @(posedge clk);
      burst_left--;
    end
    rx_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    cur_magic = MAGIC_RESET;
    cur_version = VERSION_RESET;
    cur_limit = int'(MAX_PAYLOAD_RESET);

    // register defaults: good frames, each fault, fault priority, length above 16 bits
    queue_frame(cur_magic, cur_version, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 0);
    queue_frame(cur_magic, cur_version, 16'h0000, 32'h0000_0000, 32'd1, 1);
    queue_frame(cur_magic, cur_version, 16'h5A3C, 32'h89AB_CDEF, 32'd2, 2);
    queue_frame(~cur_magic, cur_version, 16'h0001, 32'd7, 32'd0, 0);
    queue_frame(cur_magic, ~cur_version, 16'h0002, 32'd8, 32'd0, 0);
    queue_frame(cur_magic, cur_version, 16'h0003, 32'd9, 32'h0001_0000, 0);
    queue_frame(~cur_magic, ~cur_version, 16'h0004, 32'd10, 32'hFFFF_FFFF, 0);
    queue_frame(cur_magic, ~cur_version, 16'h0005, 32'd11, 32'hFFFF_FFFF, 0);
    queue_random(RANDOM_BYTES_PER_PHASE);
    play_stream();
    drain();

    configure(32'hFFFF_FFFF, 16'hFFFF, 16'd0);
    queue_frame(cur_magic, cur_version, 16'($urandom), $urandom, 32'd0, 0);
    queue_frame(cur_magic, cur_version, 16'($urandom), $urandom, 32'd1, 0);
    queue_random(RANDOM_BYTES_PER_PHASE);
    play_stream();
    drain();

    configure($urandom, 16'h0000, 16'($urandom_range(1, 40)));
    queue_frame(cur_magic, cur_version, 16'($urandom), $urandom, 32'(cur_limit), cur_limit);
    queue_frame(cur_magic, cur_version, 16'($urandom), $urandom, 32'(cur_limit + 1), 0);
    queue_random(RANDOM_BYTES_PER_PHASE);
    play_stream();
    drain();

    configure(32'h0000_0000, 16'($urandom), 16'hFFFF);
    queue_random(RANDOM_BYTES_PER_PHASE);
    play_stream();
    drain();

    configure($urandom, 16'($urandom), 16'hFFFF);
    queue_frame(cur_magic, cur_version, 16'($urandom), $urandom,
                32'(PAYLOAD_LIMIT) + 32'd1, 0);
    queue_random(RANDOM_BYTES_PER_PHASE);
    play_stream();
    drain();

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
